// ----- rtl/core/nsms_pkg.sv -----
// ----------------------------------------------------------------------------
// nsms_pkg
// types, constants and pass table of the newton-schulz matrix square root
// ----------------------------------------------------------------------------
`default_nettype none

package nsms_pkg;

  localparam int DATA_W        = 32;
  localparam int MAX_N_DEF     = 8;
  localparam int FRAC_BITS_DEF = 24;

  localparam int SIZE_W     = 4;
  localparam int ITER_W     = 4;
  localparam int SCALE_W    = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_MATRIX_SIZE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ITERATION_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE_FACTOR    = 2'd2;

  localparam logic [SIZE_W-1:0]  SIZE_RST  = 4'd8;
  localparam logic [ITER_W-1:0]  ITER_RST  = 4'd5;
  localparam logic [SCALE_W-1:0] SCALE_RST = 8'd1;

  localparam int NBUF = 5;

  typedef enum logic [2:0] {
    BUF_A,
    BUF_Y,
    BUF_Z,
    BUF_T,
    BUF_P
  } buf_e;

  typedef enum logic [1:0] {
    POST_NONE,
    POST_SUB3,
    POST_HALF,
    POST_HALFK
  } post_e;

  typedef enum logic [3:0] {
    PS_Z0,
    PS_P0,
    PS_Y0,
    PS_ZH,
    PS_LT,
    PS_LY,
    PS_CY,
    PS_LZ,
    PS_CZ,
    PS_FT,
    PS_FP
  } pass_e;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_SETUP,
    ST_ISSUE,
    ST_DRAIN,
    ST_FIN1,
    ST_FIN2,
    ST_FIN3,
    ST_NEXT,
    ST_ORD,
    ST_OCAP,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic  is_mul;
    buf_e  src_a;
    buf_e  src_b;
    buf_e  dst;
    post_e post;
  } pass_cfg_t;

  function automatic pass_cfg_t pass_cfg(pass_e p);
    pass_cfg_t cfg;
    cfg = '{is_mul: 1'b0, src_a: BUF_A, src_b: BUF_A, dst: BUF_P, post: POST_NONE};
    unique case (p)
      PS_Z0: cfg = '{is_mul: 1'b0, src_a: BUF_A, src_b: BUF_A, dst: BUF_Z, post: POST_SUB3};
      PS_P0: cfg = '{is_mul: 1'b1, src_a: BUF_A, src_b: BUF_Z, dst: BUF_P, post: POST_NONE};
      PS_Y0: cfg = '{is_mul: 1'b0, src_a: BUF_P, src_b: BUF_A, dst: BUF_Y, post: POST_HALF};
      PS_ZH: cfg = '{is_mul: 1'b0, src_a: BUF_Z, src_b: BUF_A, dst: BUF_Z, post: POST_HALF};
      PS_LT: cfg = '{is_mul: 1'b1, src_a: BUF_Z, src_b: BUF_Y, dst: BUF_T, post: POST_SUB3};
      PS_LY: cfg = '{is_mul: 1'b1, src_a: BUF_Y, src_b: BUF_T, dst: BUF_P, post: POST_HALF};
      PS_CY: cfg = '{is_mul: 1'b0, src_a: BUF_P, src_b: BUF_A, dst: BUF_Y, post: POST_NONE};
      PS_LZ: cfg = '{is_mul: 1'b1, src_a: BUF_T, src_b: BUF_Z, dst: BUF_P, post: POST_HALF};
      PS_CZ: cfg = '{is_mul: 1'b0, src_a: BUF_P, src_b: BUF_A, dst: BUF_Z, post: POST_NONE};
      PS_FT: cfg = '{is_mul: 1'b1, src_a: BUF_Z, src_b: BUF_Y, dst: BUF_T, post: POST_SUB3};
      PS_FP: cfg = '{is_mul: 1'b1, src_a: BUF_Y, src_b: BUF_T, dst: BUF_P, post: POST_HALFK};
      default: cfg = '{is_mul: 1'b0, src_a: BUF_A, src_b: BUF_A, dst: BUF_P, post: POST_NONE};
    endcase
    return cfg;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/newton_schulz_matrix_sqrt.sv -----
// ----------------------------------------------------------------------------
// newton_schulz_matrix_sqrt
// fixed-point newton-schulz square root of one n-by-n matrix on a shared mac
// ----------------------------------------------------------------------------
// load: one element per cycle, n*n transfers; the block is not ready while busy
// compute: matrix passes and elementwise passes, one result element at a time,
//   all on the single multiply-accumulate unit and the two-read buffer memory;
//   iterations i >= 2: (3i-3) product passes and (2i-1) elementwise passes
// output: n(n+1)/2 results of the upper triangle, column by column
// reset: asynchronous, clears control and configuration; buffers are not cleared
`default_nettype none

module newton_schulz_matrix_sqrt #(
  parameter int MAX_N     = nsms_pkg::MAX_N_DEF,
  parameter int FRAC_BITS = nsms_pkg::FRAC_BITS_DEF
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  logic [nsms_pkg::CFG_IDX_W-1:0]           cfg_index_i,
  input  logic [nsms_pkg::CFG_DATA_W-1:0]          cfg_data_i,
  input  logic                                     in_valid_i,
  output logic                                     in_ready_o,
  input  logic signed [nsms_pkg::DATA_W-1:0]       matrix_element_i,
  output logic                                     out_valid_o,
  input  logic                                     out_ready_i,
  output logic signed [nsms_pkg::DATA_W-1:0]       root_element_o,
  output logic                                     last_of_matrix_o,
  output logic                                     overflow_o
);

  import nsms_pkg::*;

  localparam int CELLS  = MAX_N * MAX_N;
  localparam int IDX_W  = $clog2(CELLS);
  localparam int CNT_W  = $clog2(CELLS + 1);
  localparam int N_W    = $clog2(MAX_N + 1);
  localparam int RC_W   = $clog2(MAX_N);
  localparam int ADDR_W = $clog2(NBUF * CELLS);
  localparam int PROD_W = 2 * DATA_W;
  localparam int ACC_W  = PROD_W + $clog2(MAX_N) + 1;
  localparam int SCL_W  = SCALE_W + 1;
  localparam int MK_W   = DATA_W + SCL_W;
  localparam int HV_W   = MK_W + 1;

  localparam logic signed [DATA_W-1:0]   ONE    = DATA_W'(64'd1 << FRAC_BITS);
  localparam logic signed [ACC_W-1:0]    RND    = ACC_W'(1) << (FRAC_BITS - 1);
  localparam logic signed [DATA_W+1:0]   THREE  = (DATA_W + 2)'(3) << FRAC_BITS;
  localparam logic signed [DATA_W-1:0]   SMAX   = {1'b0, {(DATA_W - 1){1'b1}}};
  localparam logic signed [DATA_W-1:0]   SMIN   = {1'b1, {(DATA_W - 1){1'b0}}};
  localparam logic signed [SCL_W-1:0]    KONE   = SCL_W'(1);
  localparam logic signed [HV_W-1:0]     HV_ONE = HV_W'(1);
  localparam logic [ITER_W-1:0]          ITER_2 = ITER_W'(2);

  function automatic logic [ADDR_W-1:0] buf_addr(buf_e b, logic [IDX_W-1:0] i);
    return ADDR_W'(b) * ADDR_W'(CELLS) + ADDR_W'(i);
  endfunction

  // configuration
  logic [SIZE_W-1:0]  size_q;
  logic [ITER_W-1:0]  iter_q;
  logic [SCALE_W-1:0] scale_q;

  // control
  state_e            state_q, state_d;
  pass_e             pass_q, pass_d;
  logic [CNT_W-1:0]  load_cnt_q, load_cnt_d;
  logic [N_W-1:0]    n_q, n_d;
  logic [RC_W-1:0]   r_q, r_d, c_q, c_d, k_q, k_d;
  logic [IDX_W-1:0]  cbase_q, cbase_d, a_idx_q, a_idx_d, b_idx_q, b_idx_d;
  logic [ITER_W-1:0] it_q, it_d;
  logic              sat_q, sat_d;
  buf_e              out_buf_q, out_buf_d;
  logic              rd_v_q, pv_q;

  // datapath
  logic [DATA_W-1:0]        mem_q [NBUF * CELLS];
  logic [DATA_W-1:0]        rda_q, rdb_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q;
  logic signed [DATA_W-1:0] s_q, res_q, root_q;
  logic signed [MK_W-1:0]   m_q;
  logic                     last_q;

  logic              mem_we, issue;
  logic [ADDR_W-1:0] mem_wa, ra, rb;
  logic [DATA_W-1:0] mem_wd;

  pass_cfg_t pc;
  logic [N_W-1:0]   n_cfg;
  logic [CNT_W-1:0] nn_cfg;
  logic [RC_W-1:0]  n_m1, k_last;
  logic             diag, is_half;

  logic signed [DATA_W-1:0] mul_b;
  logic signed [ACC_W-1:0]  acc_sh;
  logic                     f1_hi, f1_lo;
  logic signed [DATA_W-1:0] s1;
  logic signed [DATA_W+1:0] sub_v;
  logic                     sub_lo;
  logic signed [DATA_W-1:0] sub3;
  logic signed [SCL_W-1:0]  kmul;
  logic signed [MK_W-1:0]   m_v;
  logic signed [HV_W-1:0]   hh;
  logic                     h_hi, h_lo;
  logic signed [DATA_W-1:0] h_val, fin_val;

  assign pc      = pass_cfg(pass_q);
  assign n_cfg   = (size_q == '0) ? N_W'(1) :
                   (size_q > SIZE_W'(MAX_N)) ? N_W'(MAX_N) : N_W'(size_q);
  assign nn_cfg  = CNT_W'(n_cfg) * CNT_W'(n_cfg);
  assign n_m1    = RC_W'(n_q - N_W'(1));
  assign k_last  = pc.is_mul ? n_m1 : '0;
  assign diag    = (r_q == c_q);
  assign is_half = (pc.post == POST_HALF) || (pc.post == POST_HALFK);

  // rounding, saturation and post operations
  assign mul_b  = pc.is_mul ? $signed(rdb_q) : ONE;
  assign acc_sh = (acc_q + RND) >>> FRAC_BITS;
  assign f1_hi  = acc_sh > ACC_W'(SMAX);
  assign f1_lo  = acc_sh < ACC_W'(SMIN);
  assign s1     = f1_hi ? SMAX : (f1_lo ? SMIN : acc_sh[DATA_W-1:0]);
  assign sub_v  = (DATA_W + 2)'(s_q) - THREE;
  assign sub_lo = sub_v < (DATA_W + 2)'(SMIN);
  assign sub3   = sub_lo ? SMIN : sub_v[DATA_W-1:0];
  assign kmul   = (pc.post == POST_HALFK) ? $signed({1'b0, scale_q}) : KONE;
  assign m_v    = s_q * kmul;
  assign hh     = (HV_ONE - HV_W'(m_q)) >>> 1;
  assign h_hi   = hh > HV_W'(SMAX);
  assign h_lo   = hh < HV_W'(SMIN);
  assign h_val  = h_hi ? SMAX : (h_lo ? SMIN : hh[DATA_W-1:0]);
  assign fin_val = is_half ? h_val : res_q;

  // memory ports
  always_comb begin
    mem_we = 1'b0;
    mem_wa = buf_addr(BUF_A, load_cnt_q[IDX_W-1:0]);
    mem_wd = matrix_element_i;
    if (state_q == ST_LOAD && in_valid_i) begin
      mem_we = 1'b1;
    end else if (state_q == ST_FIN3) begin
      mem_we = 1'b1;
      mem_wa = buf_addr(pc.dst, IDX_W'(r_q) + cbase_q);
      mem_wd = fin_val;
    end
    if (state_q == ST_ORD) begin
      ra = buf_addr(out_buf_q, IDX_W'(r_q) + cbase_q);
    end else begin
      ra = buf_addr(pc.src_a, a_idx_q);
    end
    rb = buf_addr(pc.src_b, b_idx_q);
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    rda_q <= mem_q[ra];
    rdb_q <= mem_q[rb];
  end

  always_ff @(posedge clk_i) begin
    prod_q <= $signed(rda_q) * mul_b;
    if (state_q == ST_SETUP) begin
      acc_q <= '0;
    end else if (pv_q) begin
      acc_q <= acc_q + ACC_W'(prod_q);
    end
    if (state_q == ST_FIN1) begin
      s_q <= s1;
    end
    if (state_q == ST_FIN2) begin
      m_q   <= m_v;
      res_q <= (pc.post == POST_SUB3 && diag) ? sub3 : s_q;
    end
    if (state_q == ST_OCAP) begin
      root_q <= $signed(rda_q);
      last_q <= (c_q == n_m1) && diag;
    end
  end

  // configuration writes
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q  <= SIZE_RST;
      iter_q  <= ITER_RST;
      scale_q <= SCALE_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_MATRIX_SIZE:     size_q  <= cfg_data_i[SIZE_W-1:0];
        CFG_ITERATION_COUNT: iter_q  <= cfg_data_i[ITER_W-1:0];
        CFG_SCALE_FACTOR:    scale_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_LOAD;
      pass_q     <= PS_Z0;
      load_cnt_q <= '0;
      n_q        <= N_W'(1);
      r_q        <= '0;
      c_q        <= '0;
      k_q        <= '0;
      cbase_q    <= '0;
      a_idx_q    <= '0;
      b_idx_q    <= '0;
      it_q       <= '0;
      sat_q      <= 1'b0;
      out_buf_q  <= BUF_Y;
      rd_v_q     <= 1'b0;
      pv_q       <= 1'b0;
    end else begin
      state_q    <= state_d;
      pass_q     <= pass_d;
      load_cnt_q <= load_cnt_d;
      n_q        <= n_d;
      r_q        <= r_d;
      c_q        <= c_d;
      k_q        <= k_d;
      cbase_q    <= cbase_d;
      a_idx_q    <= a_idx_d;
      b_idx_q    <= b_idx_d;
      it_q       <= it_d;
      sat_q      <= sat_d;
      out_buf_q  <= out_buf_d;
      rd_v_q     <= issue;
      pv_q       <= rd_v_q;
    end
  end

  always_comb begin
    state_d    = state_q;
    pass_d     = pass_q;
    load_cnt_d = load_cnt_q;
    n_d        = n_q;
    r_d        = r_q;
    c_d        = c_q;
    k_d        = k_q;
    cbase_d    = cbase_q;
    a_idx_d    = a_idx_q;
    b_idx_d    = b_idx_q;
    it_d       = it_q;
    sat_d      = sat_q;
    out_buf_d  = out_buf_q;
    issue      = 1'b0;
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;

    unique case (state_q)
      ST_LOAD: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          load_cnt_d = load_cnt_q + CNT_W'(1);
          if (load_cnt_q + CNT_W'(1) >= nn_cfg) begin
            load_cnt_d = '0;
            n_d        = n_cfg;
            sat_d      = 1'b0;
            pass_d     = PS_Z0;
            r_d        = '0;
            c_d        = '0;
            cbase_d    = '0;
            state_d    = ST_SETUP;
          end
        end
      end
      ST_SETUP: begin
        a_idx_d = pc.is_mul ? IDX_W'(r_q) : IDX_W'(r_q) + cbase_q;
        b_idx_d = cbase_q;
        k_d     = '0;
        state_d = ST_ISSUE;
      end
      ST_ISSUE: begin
        issue   = 1'b1;
        a_idx_d = a_idx_q + IDX_W'(n_q);
        b_idx_d = b_idx_q + IDX_W'(1);
        k_d     = k_q + RC_W'(1);
        if (k_q == k_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!rd_v_q && !pv_q) begin
          state_d = ST_FIN1;
        end
      end
      ST_FIN1: begin
        if (f1_hi || f1_lo) begin
          sat_d = 1'b1;
        end
        state_d = ST_FIN2;
      end
      ST_FIN2: begin
        if (pc.post == POST_SUB3 && diag && sub_lo) begin
          sat_d = 1'b1;
        end
        state_d = ST_FIN3;
      end
      ST_FIN3: begin
        if (is_half && (h_hi || h_lo)) begin
          sat_d = 1'b1;
        end
        state_d = ST_NEXT;
      end
      ST_NEXT: begin
        state_d = ST_SETUP;
        if (r_q == n_m1) begin
          r_d = '0;
          if (c_q == n_m1) begin
            c_d     = '0;
            cbase_d = '0;
            unique case (pass_q)
              PS_Z0: pass_d = PS_P0;
              PS_P0: pass_d = PS_Y0;
              PS_Y0: begin
                if (iter_q < ITER_2) begin
                  out_buf_d = BUF_Y;
                  state_d   = ST_ORD;
                end else begin
                  pass_d = PS_ZH;
                end
              end
              PS_ZH: begin
                it_d   = ITER_2;
                pass_d = (ITER_2 < iter_q) ? PS_LT : PS_FT;
              end
              PS_LT: pass_d = PS_LY;
              PS_LY: pass_d = PS_CY;
              PS_CY: pass_d = PS_LZ;
              PS_LZ: pass_d = PS_CZ;
              PS_CZ: begin
                it_d   = it_q + ITER_W'(1);
                pass_d = (it_q + ITER_W'(1) < iter_q) ? PS_LT : PS_FT;
              end
              PS_FT: pass_d = PS_FP;
              PS_FP: begin
                out_buf_d = BUF_P;
                state_d   = ST_ORD;
              end
              default: pass_d = PS_Z0;
            endcase
          end else begin
            c_d     = c_q + RC_W'(1);
            cbase_d = cbase_q + IDX_W'(n_q);
          end
        end else begin
          r_d = r_q + RC_W'(1);
        end
      end
      ST_ORD: begin
        state_d = ST_OCAP;
      end
      ST_OCAP: begin
        state_d = ST_OUT;
      end
      ST_OUT: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = ST_ORD;
          if (diag) begin
            r_d = '0;
            if (c_q == n_m1) begin
              c_d     = '0;
              cbase_d = '0;
              state_d = ST_LOAD;
            end else begin
              c_d     = c_q + RC_W'(1);
              cbase_d = cbase_q + IDX_W'(n_q);
            end
          end else begin
            r_d = r_q + RC_W'(1);
          end
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  assign root_element_o   = root_q;
  assign last_of_matrix_o = last_q;
  assign overflow_o       = sat_q;

endmodule

`default_nettype wire

// ----- rtl/core/nsms_checker.sv -----
// ----------------------------------------------------------------------------
// nsms_checker
// port-level checks of the newton-schulz matrix square root
// ----------------------------------------------------------------------------
`default_nettype none

module nsms_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] root_element_o,
  input logic        last_of_matrix_o
);

  // stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(root_element_o)))
    else $error("result changed while stalled");

  // loading and delivering never overlap
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input ready while a result is shown");

  // last result of a matrix reopens the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && last_of_matrix_o) |=> in_ready_o)
    else $error("input not ready after last result");

  // no result right after an input transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !out_valid_o)
    else $error("result right after input transfer");

endmodule

bind newton_schulz_matrix_sqrt nsms_checker u_nsms_checker (.*);

`default_nettype wire

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// self-checking bench for newton_schulz_matrix_sqrt: matrices are streamed in
// column-major order under several register settings and idle patterns, and
// every packed upper-triangle result is compared against a fixed-point model
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import nsms_pkg::*;

  localparam int CELLS = 64;
  localparam int FRAC  = FRAC_BITS_DEF;
  localparam longint CYCLE_LIMIT = 4000000;

  typedef int mat_t [CELLS];
  typedef struct {
    logic signed [31:0] root;
    logic               last;
    logic               ovf;
  } root_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [31:0] matrix_element_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [31:0] root_element_o;
  logic last_of_matrix_o;
  logic overflow_o;

  always #2 clk_i = ~clk_i;

  newton_schulz_matrix_sqrt u_dut (.*);

  int    element_q [$];
  root_t root_q [$];
  int    errors = 0;
  int    send_idle_pct = 0;
  int    recv_stall_pct = 0;
  longint cycles = 0;

  // model state
  mat_t a_mem;
  int   load_cnt = 0;
  bit   sat_seen;
  int   size_reg = SIZE_RST;
  int   iter_reg = ITER_RST;
  int   scale_reg = SCALE_RST;

  function automatic int clip(logic signed [127:0] v);
    if (v > 128'sd2147483647) begin
      sat_seen = 1'b1;
      return 32'h7fffffff;
    end
    if (v < -128'sd2147483648) begin
      sat_seen = 1'b1;
      return 32'h80000000;
    end
    return int'(v);
  endfunction

  function automatic int neg_half(int x, int k);
    longint v;
    v = -longint'(x) * longint'(k);
    v = (v + 1) >>> 1;
    return clip(v);
  endfunction

  function automatic void mat_mul(input mat_t a, input mat_t b, input int n, output mat_t p);
    logic signed [127:0] acc;
    longint prod;
    p = '{default: 0};
    for (int c = 0; c < n; c++)
      for (int r = 0; r < n; r++) begin
        acc = 0;
        for (int k = 0; k < n; k++) begin
          prod = longint'(a[(r + k * n) & 63]) * longint'(b[(k + c * n) & 63]);
          acc = acc + prod;
        end
        acc = acc + (128'sd1 <<< (FRAC - 1));
        p[r + c * n] = clip(acc >>> FRAC);
      end
  endfunction

  function automatic void sub_3i(inout mat_t m, input int n);
    for (int d = 0; d < n; d++)
      m[d * (n + 1)] = clip(longint'(m[d * (n + 1)]) - (longint'(3) <<< FRAC));
  endfunction

  function automatic void halve(inout mat_t m, input int n, input int k);
    for (int i = 0; i < n * n; i++) m[i] = neg_half(m[i], k);
  endfunction

  function automatic void predict_root(int elem);
    int n;
    mat_t y, z, t, p, res;
    root_t e;
    n = size_reg < 1 ? 1 : (size_reg > MAX_N_DEF ? MAX_N_DEF : size_reg);
    a_mem[load_cnt & 63] = elem;
    load_cnt++;
    if (load_cnt < n * n) return;
    sat_seen = 1'b0;
    z = a_mem;
    sub_3i(z, n);
    mat_mul(a_mem, z, n, p);
    y = p;
    halve(y, n, 1);
    if (iter_reg < 2) begin
      res = y;
    end else begin
      halve(z, n, 1);
      for (int i = 2; i < iter_reg; i++) begin
        mat_mul(z, y, n, t);
        sub_3i(t, n);
        mat_mul(y, t, n, p);
        halve(p, n, 1);
        y = p;
        mat_mul(t, z, n, p);
        halve(p, n, 1);
        z = p;
      end
      mat_mul(z, y, n, t);
      sub_3i(t, n);
      mat_mul(y, t, n, p);
      halve(p, n, scale_reg);
      res = p;
    end
    for (int c = 0; c < n; c++)
      for (int r = 0; r <= c; r++) begin
        e.root = res[r + c * n];
        e.last = (c == n - 1 && r == c);
        e.ovf  = sat_seen;
        root_q.push_back(e);
      end
    load_cnt = 0;
  endfunction

  // driver
  always @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) predict_root(matrix_element_i);
    if (!in_valid_i || in_ready_o) begin
      if (element_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid_i <= 1'b1;
        matrix_element_i <= element_q.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    root_t e;
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    if (out_valid_o && out_ready_i) begin
      if (root_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", root_element_o);
      end else begin
        e = root_q.pop_front();
        if (e.root !== root_element_o || e.last !== last_of_matrix_o ||
            e.ovf !== overflow_o) begin
          errors++;
          if (errors <= 10)
            $display("result mismatch: exp %h/%b/%b got %h/%b/%b", e.root, e.last, e.ovf,
                     root_element_o, last_of_matrix_o, overflow_o);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("newton_schulz_matrix_sqrt: mismatch");
      $finish;
    end
  end

  task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input int val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val[7:0];
    do @(posedge clk_i); while (!(cfg_valid_i && cfg_ready_o));
    if (idx == CFG_MATRIX_SIZE) size_reg = val & 15;
    else if (idx == CFG_ITERATION_COUNT) iter_reg = val & 15;
    else if (idx == CFG_SCALE_FACTOR) scale_reg = val & 255;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain();
    do @(posedge clk_i); while (element_q.size() > 0 || in_valid_i || root_q.size() > 0);
    repeat (40) @(posedge clk_i);
  endtask

  function automatic int rand_element(int kind, bit diag);
    case (kind)
      0: return $urandom;
      1: return (diag ? (1 << FRAC) : 0) + $signed($urandom_range(1 << 21)) - (1 << 20);
      2: return $signed($urandom_range(1 << 23)) - (1 << 22);
      default: begin
        case ($urandom_range(3))
          0: return 32'h7fffffff;
          1: return 32'h80000000;
          2: return 0;
          default: return 1 << FRAC;
        endcase
      end
    endcase
  endfunction

  task automatic push_matrix(int n, int kind);
    for (int c = 0; c < n; c++)
      for (int r = 0; r < n; r++) element_q.push_back(rand_element(kind, r == c));
  endtask

  task automatic set_cfg(int n, int it, int k);
    reg_write(CFG_MATRIX_SIZE, n);
    reg_write(CFG_ITERATION_COUNT, it);
    reg_write(CFG_SCALE_FACTOR, k);
  endtask

  int sent;
  int n, it, k;

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);

    // directed: 1x1 extremes, size zero, small 2x2 cases and a write to an unused index
    set_cfg(1, 5, 1);
    element_q = '{0, 32'h7fffffff, 32'h80000000, 1 << FRAC, 4 << FRAC};
    drain();
    set_cfg(0, 1, 1);
    element_q = '{1 << FRAC, -1};
    drain();
    set_cfg(2, 2, 0);
    element_q = '{1 << FRAC, 0, 0, 1 << FRAC};
    drain();
    set_cfg(2, 15, 255);
    element_q = '{32'h00800000, 0, 0, 32'h00800000};
    drain();
    reg_write(2'd3, 8'hff);
    // size shrunk during loading
    set_cfg(3, 3, 2);
    element_q = '{1 << FRAC, 0, 0, 0, 1 << FRAC};
    drain();
    reg_write(CFG_MATRIX_SIZE, 2);
    element_q = '{2 << FRAC};
    drain();
    // size above the maximum
    set_cfg(15, 2, 1);
    push_matrix(8, 1);
    drain();

    sent = 0;
    for (int ph = 0; sent < 375; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
        default: begin send_idle_pct = 24; recv_stall_pct = 24; end
      endcase
      n = ($urandom_range(9) == 0) ? 8 : $urandom_range(1, 4);
      case ($urandom_range(4))
        0: it = 1;
        1: it = 2;
        2: it = (n > 4) ? 4 : 15;
        default: it = $urandom_range(3, (n > 4) ? 5 : 8);
      endcase
      case ($urandom_range(4))
        0: k = 0;
        1: k = 255;
        2: k = 1;
        default: k = $urandom_range(255);
      endcase
      set_cfg(n, it, k);
      for (int m = 0; m < ((n > 4) ? 1 : 4); m++) begin
        push_matrix(n, ($urandom_range(9) < 6) ? 1 : $urandom_range(3));
        sent += n * n;
      end
      drain();
    end

    send_idle_pct = 0;
    recv_stall_pct = 0;
    drain();
    if (errors == 0) begin
      $display("newton_schulz_matrix_sqrt: match");
    end else begin
      $display("newton_schulz_matrix_sqrt: mismatch");
    end
    $finish;
  end
endmodule

// ----- newton_schulz_matrix_sqrt.f -----
rtl/core/nsms_pkg.sv
rtl/core/newton_schulz_matrix_sqrt.sv
rtl/core/nsms_checker.sv
tb/tb.sv
